[rtl/gamepad_report_decoder_macros.svh]
// assertion macros used by the gamepad report decoder datapath
`ifndef GAMEPAD_REPORT_DECODER_MACROS_SVH
`define GAMEPAD_REPORT_DECODER_MACROS_SVH

// clocked check, disabled while reset is asserted
`define GRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define GRD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/grd_pkg.sv]
// shared types and constants of the gamepad report decoder
package grd_pkg;

	// report layout
	localparam int CAPTURE_BYTES    = 12;
	localparam int REPORT_MIN_BYTES = 13;
	localparam int COUNT_W          = 4;
	localparam int AXIS_W           = 12;
	localparam int NUM_AXES         = 4;
	localparam int OUT_AXIS_W       = 16;

	// default fraction bits of the normalized axes
	localparam int AXIS_FRACTION_BITS_DEF = 15;

	// configuration port
	localparam int CFG_W      = 12;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_LEFT_X_CENTER  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEFT_Y_CENTER  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT_X_CENTER = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT_Y_CENTER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_EXTENT_POS     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_EXTENT_NEG     = 3'd5;

	localparam logic [CFG_W-1:0] CENTER_RESET = 12'd2048;
	localparam logic [CFG_W-1:0] EXTENT_RESET = 12'd1600;

	// axis codes, in the order the sequencer visits them
	localparam logic [1:0] AXIS_LX = 2'd0;
	localparam logic [1:0] AXIS_LY = 2'd1;
	localparam logic [1:0] AXIS_RX = 2'd2;
	localparam logic [1:0] AXIS_RY = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_STORE,
		ST_LOAD
	} grd_state_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][CFG_W-1:0] center;
		logic [CFG_W-1:0]               ext_pos;
		logic [CFG_W-1:0]               ext_neg;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       div_start;
		logic       div_step;
		logic       div_store;
		logic       out_load;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic long_end;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

[rtl/grd_cfg.sv]
// configuration registers behind the apb-style port
module grd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [grd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [grd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [grd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output grd_pkg::cfg_t                  cfg
);
	import grd_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	logic [CFG_W-1:0]     rd_val;
	cfg_t                 cfg_q;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes, low bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center  <= {NUM_AXES{CENTER_RESET}};
			cfg_q.ext_pos <= EXTENT_RESET;
			cfg_q.ext_neg <= EXTENT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_LEFT_X_CENTER:  cfg_q.center[AXIS_LX] <= pwdata[CFG_W-1:0];
				REG_LEFT_Y_CENTER:  cfg_q.center[AXIS_LY] <= pwdata[CFG_W-1:0];
				REG_RIGHT_X_CENTER: cfg_q.center[AXIS_RX] <= pwdata[CFG_W-1:0];
				REG_RIGHT_Y_CENTER: cfg_q.center[AXIS_RY] <= pwdata[CFG_W-1:0];
				REG_EXTENT_POS:     cfg_q.ext_pos         <= pwdata[CFG_W-1:0];
				REG_EXTENT_NEG:     cfg_q.ext_neg         <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_LEFT_X_CENTER:  rd_val = cfg_q.center[AXIS_LX];
			REG_LEFT_Y_CENTER:  rd_val = cfg_q.center[AXIS_LY];
			REG_RIGHT_X_CENTER: rd_val = cfg_q.center[AXIS_RX];
			REG_RIGHT_Y_CENTER: rd_val = cfg_q.center[AXIS_RY];
			REG_EXTENT_POS:     rd_val = cfg_q.ext_pos;
			REG_EXTENT_NEG:     rd_val = cfg_q.ext_neg;
			default:            rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DATA_W-CFG_W){1'b0}}, rd_val};

endmodule

[rtl/grd_ctrl.sv]
// sequencer: byte intake, four axis divisions, result hand-off
module grd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  grd_pkg::status_t status,
	output grd_pkg::cmd_t    cmd
);
	import grd_pkg::*;

	grd_state_t state_q, state_d;
	logic [1:0] axis_q;
	logic       axis_last;

	assign axis_last = (axis_q == 2'(NUM_AXES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && status.long_end) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_DIV;
			ST_DIV:   if (status.div_last) state_d = ST_STORE;
			ST_STORE: state_d = axis_last ? ST_LOAD : ST_SETUP;
			ST_LOAD:  if (status.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SETUP: cmd.div_start = 1'b1;
			ST_DIV:   cmd.div_step  = 1'b1;
			ST_STORE: cmd.div_store = 1'b1;
			ST_LOAD:  cmd.out_load  = status.out_free;
			default: ;
		endcase
	end

	// state and axis counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_LX;
		end else begin
			state_q <= state_d;
			if (state_q == ST_STORE) begin
				axis_q <= axis_q + 2'd1;
			end
		end
	end

endmodule

[rtl/grd_datapath.sv]
// byte capture, shared restoring divider, axis results and output register
module grd_datapath #(
	parameter int AXIS_FRACTION_BITS = grd_pkg::AXIS_FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  grd_pkg::cmd_t         cmd,
	output grd_pkg::status_t      status,
	input  grd_pkg::cfg_t         cfg,
	input  logic [7:0]            report_byte,
	input  logic                  end_of_report,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            report_id,
	output logic [14:0]           buttons,
	output logic [3:0]            hat,
	output logic signed [15:0]    left_x,
	output logic signed [15:0]    left_y,
	output logic signed [15:0]    right_x,
	output logic signed [15:0]    right_y,
	output logic                  left_trigger,
	output logic                  right_trigger
);
	import grd_pkg::*;

	// divider sizing follows the fraction bits
	localparam int    NUM_W   = AXIS_W + AXIS_FRACTION_BITS;
	localparam int    BITS_W  = $clog2(NUM_W + 1);
	localparam longint LIM    = (AXIS_FRACTION_BITS >= 15) ? 64'd32767 :
		((64'd1 << AXIS_FRACTION_BITS) - 64'd1);
	localparam int    MAG_W   = OUT_AXIS_W - 1;

	localparam logic [3:0] HAT_CENTER     = 4'd0;
	localparam logic [3:0] HAT_UP         = 4'd1;
	localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
	localparam logic [3:0] HAT_RIGHT      = 4'd3;
	localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
	localparam logic [3:0] HAT_DOWN       = 4'd5;
	localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
	localparam logic [3:0] HAT_LEFT       = 4'd7;
	localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

	logic [COUNT_W-1:0]  count_q;
	logic [7:0]          cap_q [CAPTURE_BYTES];

	logic [NUM_W-1:0]    num_q;
	logic [AXIS_W-1:0]   rem_q;
	logic [AXIS_W-1:0]   div_q;
	logic [BITS_W-1:0]   bits_left_q;
	logic                zero_q;
	logic                flip_q;
	logic [OUT_AXIS_W-1:0] axis_res_q [NUM_AXES];
	logic                out_valid_q;

	logic [AXIS_W-1:0]   raw;
	logic [AXIS_W:0]     diff;
	logic                neg;
	logic [AXIS_W-1:0]   mag;
	logic [AXIS_W-1:0]   extent;
	logic [AXIS_W:0]     trial;
	logic                fits;
	logic [MAG_W-1:0]    sat_mag;
	logic [OUT_AXIS_W-1:0] axis_val;
	logic                out_free;
	logic [7:0]          rb, sb, lb;
	logic                up, down, lf, rt;
	logic [3:0]          hat_d;
	logic [14:0]         btn_d;

	// byte counter and capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.capture) begin
			if (end_of_report) begin
				count_q <= '0;
			end else if (count_q < COUNT_W'(REPORT_MIN_BYTES)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && (count_q < COUNT_W'(CAPTURE_BYTES))) begin
			cap_q[count_q] <= report_byte;
		end
	end

	// raw sample and centre of the selected axis
	always_comb begin
		case (cmd.axis)
			AXIS_LX: raw = {cap_q[7][3:0], cap_q[6]};
			AXIS_LY: raw = {cap_q[8], cap_q[7][7:4]};
			AXIS_RX: raw = {cap_q[10][3:0], cap_q[9]};
			AXIS_RY: raw = {cap_q[11], cap_q[10][7:4]};
			default: raw = '0;
		endcase
	end

	assign diff   = {1'b0, raw} - {1'b0, cfg.center[cmd.axis]};
	assign neg    = diff[AXIS_W];
	assign mag    = neg ? AXIS_W'(-diff) : diff[AXIS_W-1:0];
	assign extent = neg ? cfg.ext_neg : cfg.ext_pos;

	// one quotient bit per step
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= '0;
		end else if (cmd.div_start) begin
			bits_left_q <= BITS_W'(NUM_W);
		end else if (cmd.div_step) begin
			bits_left_q <= bits_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q  <= NUM_W'(mag) << AXIS_FRACTION_BITS;
			rem_q  <= '0;
			div_q  <= extent;
			zero_q <= (extent == '0);
			flip_q <= neg ^ ((cmd.axis == AXIS_LY) || (cmd.axis == AXIS_RY));
		end else if (cmd.div_step) begin
			rem_q <= fits ? AXIS_W'(trial - {1'b0, div_q}) : trial[AXIS_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	// saturate, apply sign, store per axis
	assign sat_mag  = (num_q > NUM_W'(LIM)) ? MAG_W'(LIM) : num_q[MAG_W-1:0];
	assign axis_val = zero_q ? '0 :
		(flip_q ? OUT_AXIS_W'(-{1'b0, sat_mag}) : {1'b0, sat_mag});

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			axis_res_q[cmd.axis] <= axis_val;
		end
	end

	// button and hat decode
	assign rb = cap_q[3];
	assign sb = cap_q[4];
	assign lb = cap_q[5];
	assign down = lb[0];
	assign up   = lb[1];
	assign rt   = lb[2];
	assign lf   = lb[3];

	assign btn_d = {sb[5], sb[2], sb[3], rb[6], lb[6], rt, lf, down, up,
		rb[0], rb[1], rb[2], rb[3], sb[0], sb[1]};

	always_comb begin
		if (up && rt)        hat_d = HAT_UP_RIGHT;
		else if (down && rt) hat_d = HAT_DOWN_RIGHT;
		else if (down && lf) hat_d = HAT_DOWN_LEFT;
		else if (up && lf)   hat_d = HAT_UP_LEFT;
		else if (up)         hat_d = HAT_UP;
		else if (rt)         hat_d = HAT_RIGHT;
		else if (down)       hat_d = HAT_DOWN;
		else if (lf)         hat_d = HAT_LEFT;
		else                 hat_d = HAT_CENTER;
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			report_id     <= cap_q[0];
			buttons       <= btn_d;
			hat           <= hat_d;
			left_x        <= axis_res_q[AXIS_LX];
			left_y        <= axis_res_q[AXIS_LY];
			right_x       <= axis_res_q[AXIS_RX];
			right_y       <= axis_res_q[AXIS_RY];
			left_trigger  <= lb[7];
			right_trigger <= rb[7];
		end
	end

	assign out_valid       = out_valid_q;
	assign status.long_end = end_of_report && (count_q >= COUNT_W'(REPORT_MIN_BYTES - 1));
	assign status.div_last = (bits_left_q == BITS_W'(1));
	assign status.out_free = out_free;

	`include "gamepad_report_decoder_macros.svh"

	`GRD_ASSERT(a_load_into_free, cmd.out_load |-> out_free, "result loaded over a pending beat")
	`GRD_ASSERT(a_step_in_range, cmd.div_step |-> (bits_left_q != '0), "divider stepped past its end")
	`GRD_ASSERT(a_capture_frozen, cmd.div_step |=> $stable(count_q), "bytes taken while dividing")
	`GRD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q, "result valid during reset")

endmodule

[rtl/gamepad_report_decoder.sv]
// top level of the gamepad report decoder
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | report_byte, end_of_report
//  result   | out_valid / out_stall| report_id, buttons, hat, axes, triggers
//  config   | apb psel/penable     | paddr, pwdata, prdata, pready
//
// bytes are taken one per cycle while in_stall is low; a report's final byte of at
// least 13 bytes starts four divisions through one shared restoring divider,
// each taking 12 + AXIS_FRACTION_BITS steps, and the input stalls after that
// byte until the result is loaded into the output register.
// the result then sits in an output register while new bytes are accepted;
// a result still waiting at the end of the next long report holds the input off.
// reset (arst_n low) clears the byte count, sequencer and valid flags at once.
module gamepad_report_decoder #(
	parameter int AXIS_FRACTION_BITS = grd_pkg::AXIS_FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     report_byte,
	input  logic                           end_of_report,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     report_id,
	output logic [14:0]                    buttons,
	output logic [3:0]                     hat,
	output logic signed [15:0]             left_x,
	output logic signed [15:0]             left_y,
	output logic signed [15:0]             right_x,
	output logic signed [15:0]             right_y,
	output logic                           left_trigger,
	output logic                           right_trigger,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [grd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [grd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [grd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import grd_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// configuration registers
	grd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	grd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// capture, divider and output register
	grd_datapath #(
		.AXIS_FRACTION_BITS (AXIS_FRACTION_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg           (cfg),
		.report_byte   (report_byte),
		.end_of_report (end_of_report),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.report_id     (report_id),
		.buttons       (buttons),
		.hat           (hat),
		.left_x        (left_x),
		.left_y        (left_y),
		.right_x       (right_x),
		.right_y       (right_y),
		.left_trigger  (left_trigger),
		.right_trigger (right_trigger)
	);

endmodule

[verif/gamepad_report_checker.sv]
`timescale 1ns / 100ps
// checker of the gamepad report decoder: predicts every decoded state and compares each result beat
module gamepad_report_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     report_byte,
	input  logic                           end_of_report,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [7:0]                     report_id,
	input  logic [14:0]                    buttons,
	input  logic [3:0]                     hat,
	input  logic signed [15:0]             left_x,
	input  logic signed [15:0]             left_y,
	input  logic signed [15:0]             right_x,
	input  logic signed [15:0]             right_y,
	input  logic                           left_trigger,
	input  logic                           right_trigger,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [grd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [grd_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           pready,
	output int                             err_count,
	output int                             pending
);
	import grd_pkg::*;

	localparam int     FRAC       = AXIS_FRACTION_BITS_DEF;
	localparam longint FULL_SCALE = longint'(1) <<< FRAC;
	localparam longint AXIS_LIM   = (FULL_SCALE - 1 > 32767) ? 32767 : FULL_SCALE - 1;

	// hat codes, clockwise from up
	localparam logic [3:0] HAT_CENTRED    = 4'd0;
	localparam logic [3:0] HAT_UP         = 4'd1;
	localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
	localparam logic [3:0] HAT_RIGHT      = 4'd3;
	localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
	localparam logic [3:0] HAT_DOWN       = 4'd5;
	localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
	localparam logic [3:0] HAT_LEFT       = 4'd7;
	localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

	typedef struct packed {
		logic [7:0]         report_id;
		logic [14:0]        buttons;
		logic [3:0]         hat;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic               left_trigger;
		logic               right_trigger;
	} pad_state_t;

	logic [CFG_W-1:0]   center [NUM_AXES];
	logic [CFG_W-1:0]   ext_pos;
	logic [CFG_W-1:0]   ext_neg;
	logic [COUNT_W-1:0] bytes_seen;
	logic [7:0]         report_buf [CAPTURE_BYTES];
	pad_state_t         expected_states [$];

	// deflection against centre, scaled by the extent of its sign, truncated and clamped
	function automatic longint scale_axis(logic [11:0] raw, logic [CFG_W-1:0] mid);
		longint r;
		longint m;
		longint delta;
		longint divisor;
		longint q;
		r = raw;
		m = mid;
		delta = r - m;
		if (delta >= 0)
			divisor = ext_pos;
		else
			divisor = ext_neg;
		if (divisor == 0)
			return 0;
		q = (delta * FULL_SCALE) / divisor;
		if (q > AXIS_LIM)
			q = AXIS_LIM;
		if (q < -AXIS_LIM)
			q = -AXIS_LIM;
		return q;
	endfunction

	// diagonals win over single directions
	function automatic logic [3:0] hat_of(logic go_up, logic go_down, logic go_left,
			logic go_right);
		if (go_up && go_right) return HAT_UP_RIGHT;
		if (go_down && go_right) return HAT_DOWN_RIGHT;
		if (go_down && go_left) return HAT_DOWN_LEFT;
		if (go_up && go_left) return HAT_UP_LEFT;
		if (go_up) return HAT_UP;
		if (go_right) return HAT_RIGHT;
		if (go_down) return HAT_DOWN;
		if (go_left) return HAT_LEFT;
		return HAT_CENTRED;
	endfunction

	// decoded state of the captured report
	function automatic pad_state_t decode_report();
		pad_state_t st;
		logic [7:0] rb;
		logic [7:0] sb;
		logic [7:0] lb;
		longint     v;
		rb = report_buf[3];
		sb = report_buf[4];
		lb = report_buf[5];
		st.report_id = report_buf[0];
		st.buttons = {sb[5], sb[2], sb[3], rb[6], lb[6], lb[2], lb[3], lb[0], lb[1],
			rb[0], rb[1], rb[2], rb[3], sb[0], sb[1]};
		st.hat = hat_of(lb[1], lb[0], lb[3], lb[2]);
		v = scale_axis({report_buf[7][3:0], report_buf[6]}, center[0]);
		st.left_x = v[15:0];
		v = -scale_axis({report_buf[8], report_buf[7][7:4]}, center[1]);
		st.left_y = v[15:0];
		v = scale_axis({report_buf[10][3:0], report_buf[9]}, center[2]);
		st.right_x = v[15:0];
		v = -scale_axis({report_buf[11], report_buf[10][7:4]}, center[3]);
		st.right_y = v[15:0];
		st.left_trigger = lb[7];
		st.right_trigger = rb[7];
		return st;
	endfunction

	task automatic check_field(string field, logic signed [63:0] exp_v,
			logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			if (err_count < 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field,
					exp_v, act_v);
			err_count++;
		end
	endtask

	// register writes, result beats, then byte beats
	always @(posedge clk or negedge arst_n) begin
		pad_state_t want;
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++)
				center[a] = CENTER_RESET;
			ext_pos = EXTENT_RESET;
			ext_neg = EXTENT_RESET;
			bytes_seen = '0;
			expected_states.delete();
			err_count = 0;
			pending = 0;
		end else begin
			// register write on the access cycle
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_LEFT_X_CENTER:  center[0] = pwdata[CFG_W-1:0];
					REG_LEFT_Y_CENTER:  center[1] = pwdata[CFG_W-1:0];
					REG_RIGHT_X_CENTER: center[2] = pwdata[CFG_W-1:0];
					REG_RIGHT_Y_CENTER: center[3] = pwdata[CFG_W-1:0];
					REG_EXTENT_POS:     ext_pos = pwdata[CFG_W-1:0];
					REG_EXTENT_NEG:     ext_neg = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end

			// result beat against the oldest decoded state
			if (out_valid && !out_stall) begin
				if (expected_states.size() == 0) begin
					if (err_count < 10)
						$display("%0t: result beat with no decoded state waiting", $realtime);
					err_count++;
				end else begin
					want = expected_states.pop_front();
					check_field("report_id", want.report_id, report_id);
					check_field("buttons", want.buttons, buttons);
					check_field("hat", want.hat, hat);
					check_field("left_x", $signed(want.left_x), left_x);
					check_field("left_y", $signed(want.left_y), left_y);
					check_field("right_x", $signed(want.right_x), right_x);
					check_field("right_y", $signed(want.right_y), right_y);
					check_field("left_trigger", want.left_trigger, left_trigger);
					check_field("right_trigger", want.right_trigger, right_trigger);
				end
			end

			// byte beat: capture, count, decode at the end of a long report
			if (in_valid && !in_stall) begin
				if (bytes_seen < CAPTURE_BYTES)
					report_buf[bytes_seen] = report_byte;
				if (bytes_seen < REPORT_MIN_BYTES)
					bytes_seen++;
				if (end_of_report) begin
					if (bytes_seen >= REPORT_MIN_BYTES)
						expected_states.push_back(decode_report());
					bytes_seen = '0;
				end
			end
			pending = expected_states.size();
		end
	end

endmodule

[verif/tb_gamepad_report_decoder.sv]
`timescale 1ns / 100ps
// testbench top of the gamepad report decoder: reports, register settings and the verdict
module tb_gamepad_report_decoder;
	import grd_pkg::*;

	localparam int FRAC              = AXIS_FRACTION_BITS_DEF;
	localparam int DRAIN_CYCLES      = 4 * (FRAC + 14) + 20;
	localparam int HOLD_CYCLES       = 600;
	localparam int REPORTS_PER_PHASE = 5;

	// unused register slots, writes there are dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            report_byte = '0;
	logic                  end_of_report = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            report_id;
	logic [14:0]           buttons;
	logic [3:0]            hat;
	logic signed [15:0]    left_x;
	logic signed [15:0]    left_y;
	logic signed [15:0]    right_x;
	logic signed [15:0]    right_y;
	logic                  left_trigger;
	logic                  right_trigger;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int err_count;
	int pending;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;

	logic [7:0]       rep_bytes [32];
	logic [CFG_W-1:0] cur_center [NUM_AXES];

	gamepad_report_decoder dut (.*);

	gamepad_report_checker u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_gamepad_report_decoder failed");
		$finish;
	end

	// result side: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_taken) begin
			hold_taken = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// one byte beat, entered and left at a falling edge
	task automatic send_beat(logic [7:0] b, logic last);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		report_byte <= b;
		end_of_report <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_report(int len);
		for (int i = 0; i < len; i++)
			send_beat(rep_bytes[i], i == len - 1);
	endtask

	// raw axis sample: rails, centre, near centre or anywhere
	function automatic logic [11:0] pick_axis(logic [CFG_W-1:0] mid);
		int v;
		case ($urandom_range(5))
			0: return 12'd0;
			1: return 12'hfff;
			2: return mid;
			3: begin
				v = int'(mid) + int'($urandom_range(8)) - 4;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				return v[11:0];
			end
			default: return 12'($urandom());
		endcase
	endfunction

	task automatic fill_random_report();
		logic [11:0] ax [NUM_AXES];
		for (int i = 0; i < 32; i++)
			rep_bytes[i] = 8'($urandom());
		for (int a = 0; a < NUM_AXES; a++)
			ax[a] = pick_axis(cur_center[a]);
		rep_bytes[6]  = ax[0][7:0];
		rep_bytes[7]  = {ax[1][3:0], ax[0][11:8]};
		rep_bytes[8]  = ax[1][11:4];
		rep_bytes[9]  = ax[2][7:0];
		rep_bytes[10] = {ax[3][3:0], ax[2][11:8]};
		rep_bytes[11] = ax[3][11:4];
	endtask

	// mostly well-formed reports, some long, some cut short
	task automatic random_reports(int n);
		int pick;
		int len;
		repeat (n) begin
			fill_random_report();
			pick = $urandom_range(99);
			if (pick < 70)
				len = REPORT_MIN_BYTES;
			else if (pick < 85)
				len = $urandom_range(20, REPORT_MIN_BYTES + 1);
			else
				len = $urandom_range(REPORT_MIN_BYTES - 1, 1);
			send_report(len);
		end
	endtask

	// wait for every result, then let the divider settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		logic [APB_DATA_W-1:0] word;
		word = $urandom();
		word[CFG_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [CFG_W-1:0] lx, logic [CFG_W-1:0] ly,
			logic [CFG_W-1:0] rx, logic [CFG_W-1:0] ry,
			logic [CFG_W-1:0] ep, logic [CFG_W-1:0] en);
		wait_idle();
		apb_write(REG_LEFT_X_CENTER, lx);
		apb_write(REG_LEFT_Y_CENTER, ly);
		apb_write(REG_RIGHT_X_CENTER, rx);
		apb_write(REG_RIGHT_Y_CENTER, ry);
		apb_write(REG_EXTENT_POS, ep);
		apb_write(REG_EXTENT_NEG, en);
		cur_center[0] = lx;
		cur_center[1] = ly;
		cur_center[2] = rx;
		cur_center[3] = ry;
	endtask

	initial begin
		for (int a = 0; a < NUM_AXES; a++)
			cur_center[a] = CENTER_RESET;
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles a third of the time, receiver two thirds
		snd_idle_pct = 34;
		rcv_idle_pct <= 69;

		// all ones: every button, all directions, axes on the top rail
		for (int i = 0; i < 32; i++)
			rep_bytes[i] = 8'hff;
		send_report(REPORT_MIN_BYTES);
		// short report gives nothing
		rep_bytes[0] = 8'h5a;
		rep_bytes[1] = 8'ha5;
		send_report(2);
		// all zeros: nothing pressed, axes on the bottom rail
		for (int i = 0; i < 32; i++)
			rep_bytes[i] = 8'h00;
		send_report(REPORT_MIN_BYTES);
		random_reports(REPORTS_PER_PHASE);

		// centres at zero, widest extents
		set_config(12'd0, 12'd0, 12'd0, 12'd0, 12'hfff, 12'hfff);
		random_reports(REPORTS_PER_PHASE);

		// roles swapped; centres at the top, unit extents saturate
		snd_idle_pct = 69;
		rcv_idle_pct <= 34;
		set_config(12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'd1, 12'd1);
		random_reports(REPORTS_PER_PHASE);

		// zero positive extent, receiver held off long enough to back up the input
		set_config(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
			12'd0, 12'($urandom()));
		hold_req <= hold_req + 1;
		random_reports(REPORTS_PER_PHASE);

		// no idling; zero negative extent
		snd_idle_pct = 0;
		rcv_idle_pct <= 0;
		set_config(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
			12'($urandom()), 12'd0);
		random_reports(REPORTS_PER_PHASE);

		// writes to unused slots are dropped, then a fully random setting
		wait_idle();
		apb_write(REG_SPARE_6, 12'($urandom()));
		apb_write(REG_SPARE_7, 12'($urandom()));
		set_config(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
			12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)));
		random_reports(REPORTS_PER_PHASE);

		wait_idle();
		if (err_count == 0 && pending == 0)
			$display("tb_gamepad_report_decoder passed");
		else
			$display("tb_gamepad_report_decoder failed");
		$finish;
	end

endmodule
